// ----- rtl/core/crpds_pkg.sv -----
package crpds_pkg;

   // request and result payloads
   typedef struct packed {
      logic signed [15:0] sin_yaw;
      logic signed [15:0] cos_yaw;
      logic signed [15:0] sin_pitch;
      logic signed [15:0] cos_pitch;
   } req_type;

   typedef struct packed {
      logic               item_kind;
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic        [15:0] red;
      logic        [15:0] green;
      logic        [15:0] blue;
      logic        [4:0]  vertex_index;
      logic               last;
   } rsp_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic    valid;
      req_type data;
   } queue_head_type;

   // divider status toward the back end
   typedef struct packed {
      logic               done;
      logic signed [15:0] quot;
   } div_result_type;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // divider widths: numerator magnitude, denominator, working remainder
   localparam int MAG_W = 50;
   localparam int DEN_W = 36;
   localparam int REM_W = 54;
   localparam int QUOT_W = 16;

   localparam logic [16:0] SCALE_X = 17'd75366;
   localparam logic [17:0] SCALE_Y = 18'd134349;

   localparam logic item_vertex = 1'b0;
   localparam logic item_index  = 1'b1;

   // corner numbers around each face
   localparam logic [2:0] FACE_RING [6][4] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd5, 3'd4, 3'd7, 3'd6}, '{3'd4, 3'd0, 3'd3, 3'd7},
      '{3'd1, 3'd5, 3'd6, 3'd2}, '{3'd3, 3'd2, 3'd6, 3'd7}, '{3'd4, 3'd5, 3'd1, 3'd0}
   };

   // face colors in hundredths
   localparam logic [6:0] FACE_HUE [6][3] = '{
      '{7'd95, 7'd16, 7'd12}, '{7'd12, 7'd72, 7'd100}, '{7'd20, 7'd95, 7'd36},
      '{7'd100, 7'd42, 7'd10}, '{7'd72, 7'd22, 7'd100}, '{7'd100, 7'd88, 7'd12}
   };

   localparam logic [1:0] TRI_PATTERN [6] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0};

   typedef logic [23:0][2:0][15:0] shade_lut_type;

   // shaded colors, one row per emitted vertex, worked out at elaboration
   function automatic shade_lut_type build_shade_lut();
      shade_lut_type lut;
      longint prod;
      lut = '0;
      for (int f = 0; f < 6; f++) begin
         for (int c = 0; c < 4; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
               prod = longint'(FACE_HUE[f][ch]) * longint'(72 + 9 * c) * 64'sd65536;
               lut[f * 4 + c][ch] = 16'((prod + 64'sd5000) / 10000);
            end
         end
      end
      return lut;
   endfunction

   localparam shade_lut_type SHADE_LUT = build_shade_lut();

endpackage

// ----- rtl/core/crpds_front.sv -----
module crpds_front #(
   parameter int QUEUE_DEPTH = crpds_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  crpds_pkg::req_type       req_data,
   input  logic                     pop,
   output logic                     busy,
   output crpds_pkg::queue_head_type head
);
   import crpds_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, take;

   // accept a request whenever a slot is free
   assign busy = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign take = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ff];

   // advance pointers and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (take) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // hold the request payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= req_data;
      end
   end

endmodule

// ----- rtl/core/crpds_div.sv -----
module crpds_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crpds_pkg::MAG_W-1:0]   mag,
   input  logic                          neg,
   input  logic [crpds_pkg::DEN_W-1:0]   den,
   output crpds_pkg::div_result_type     result
);
   import crpds_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in, done_ff, done_in;
   logic              sat_ff, sat_in, neg_ff, neg_in;
   logic [REM_W-1:0]  num_start, den_start;

   // round to nearest: (2|n| + d) / (2d)
   assign num_start = REM_W'({mag, 1'b0}) + REM_W'(den);
   assign den_start = REM_W'({den, 1'b0});

   // one restoring step per cycle, quotient bit 15 first
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num_start;
         dsr_in = den_start << 15;
         sat_in = (num_start >= (den_start << 16));
         neg_in = neg;
         q_in   = '0;
         cnt_in = 5'd16;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         dsr_in = dsr_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
      neg_ff <= neg_in;
   end

   // apply sign and saturate to 16 bits
   always_comb begin
      result.done = done_ff;
      if (neg_ff) begin
         result.quot = (sat_ff || (q_ff > 16'd32768)) ? 16'sh8000 : 16'(-q_ff);
      end else begin
         result.quot = (sat_ff || (q_ff > 16'd32767)) ? 16'sh7fff : q_ff;
      end
   end

endmodule

// ----- rtl/core/crpds_back.sv -----
module crpds_back (
   input  logic                      clock,
   input  logic                      reset,
   input  crpds_pkg::queue_head_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   output crpds_pkg::rsp_type        rsp_data
);
   import crpds_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_ROT   = 11'b000_0000_0010,
      ST_MUL   = 11'b000_0000_0100,
      ST_NUMX  = 11'b000_0000_1000,
      ST_DIVX  = 11'b000_0001_0000,
      ST_NUMY  = 11'b000_0010_0000,
      ST_DIVY  = 11'b000_0100_0000,
      ST_FACE  = 11'b000_1000_0000,
      ST_SORT  = 11'b001_0000_0000,
      ST_EMITV = 11'b010_0000_0000,
      ST_EMITI = 11'b100_0000_0000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [2:0]         corner_ff, corner_in;
   logic [4:0]         vert_ff, vert_in;
   logic [2:0]         slot_ff, slot_in, tri_ff, tri_in;
   req_type            ang_ff, ang_in;
   logic signed [17:0] rx_ff, rx_in, rz_ff, rz_in;
   logic signed [34:0] ry_ff, ry_in;
   logic signed [37:0] cam_ff, cam_in;
   logic [DEN_W-1:0]   dv_ff, dv_in, den_ff, den_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in, go_ff, go_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [37:0] depth_ff [8];
   logic signed [15:0] px_ff [8];
   logic signed [15:0] py_ff [8];
   logic signed [39:0] fd_ff [6];
   logic [2:0]         order_ff [6];

   div_result_type     div_res;

   logic               ax, ay, az;
   logic signed [17:0] sy18, cy18;
   logic signed [34:0] cx35;
   logic signed [37:0] sx38;
   logic signed [33:0] mul_s, mul_c;
   logic signed [17:0] rx_calc, rz_calc;
   logic [16:0]        abs_rx;
   logic [31:0]        abs_ry;
   logic [DEN_W-1:0]   dv_calc;
   logic [2:0]         rank;
   logic [2:0]         vtx;

   // corner signs: x set on corners 1,2,5,6; y on bit 1; z on bit 2
   assign ax = corner_ff[0] ^ corner_ff[1];
   assign ay = corner_ff[1];
   assign az = corner_ff[2];

   assign sy18 = {{2{ang_ff.sin_yaw[15]}}, ang_ff.sin_yaw};
   assign cy18 = {{2{ang_ff.cos_yaw[15]}}, ang_ff.cos_yaw};
   assign cx35 = {{19{ang_ff.cos_pitch[15]}}, ang_ff.cos_pitch};
   assign sx38 = {{22{ang_ff.sin_pitch[15]}}, ang_ff.sin_pitch};

   // yaw rotation: sign selects only
   assign rx_calc = (ax ? cy18 : -cy18) + (az ? sy18 : -sy18);
   assign rz_calc = (ax ? -sy18 : sy18) + (az ? cy18 : -cy18);

   // pitch rotation products
   assign mul_s = $signed(ang_ff.sin_pitch) * rz_ff;
   assign mul_c = $signed(ang_ff.cos_pitch) * rz_ff;

   assign abs_rx  = rx_ff[17] ? 17'(-rx_ff) : rx_ff[16:0];
   assign abs_ry  = ry_ff[34] ? 32'(-ry_ff) : ry_ff[31:0];
   assign dv_calc = (cam_ff < 38'sh0_4000_0000) ? DEN_W'(36'h0_4000_0000) : cam_ff[DEN_W-1:0];

   // rank of one face: deeper faces first, ties by face number
   always_comb begin
      rank = '0;
      for (int g = 0; g < 6; g++) begin
         if ((fd_ff[g] > fd_ff[corner_ff]) ||
             ((fd_ff[g] == fd_ff[corner_ff]) && (3'(g) < corner_ff))) begin
            rank = rank + 3'd1;
         end
      end
   end

   assign vtx = FACE_RING[vert_ff[4:2]][vert_ff[1:0]];

   // sequence one request
   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      vert_in      = vert_ff;
      slot_in      = slot_ff;
      tri_in       = tri_ff;
      ang_in       = ang_ff;
      rx_in        = rx_ff;
      rz_in        = rz_ff;
      ry_in        = ry_ff;
      cam_in       = cam_ff;
      dv_in        = dv_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      go_in        = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop       = 1'b1;
               ang_in    = head.data;
               corner_in = '0;
               state_in  = ST_ROT;
            end
         end
         ST_ROT: begin
            rx_in    = rx_calc;
            rz_in    = rz_calc;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ry_in    = ((ay ? cx35 : -cx35) <<< 15) - {mul_s[33], mul_s};
            cam_in   = ((ay ? sx38 : -sx38) <<< 15) + {{4{mul_c[33]}}, mul_c}
                       + 38'sh1_0000_0000;
            state_in = ST_NUMX;
         end
         ST_NUMX: begin
            dv_in    = dv_calc;
            den_in   = dv_calc;
            mag_in   = (MAG_W'(abs_rx) * MAG_W'(SCALE_X)) << 12;
            neg_in   = rx_ff[17];
            go_in    = 1'b1;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            if (div_res.done) begin
               state_in = ST_NUMY;
            end
         end
         ST_NUMY: begin
            den_in   = dv_ff << 3;
            mag_in   = MAG_W'(abs_ry) * MAG_W'(SCALE_Y);
            neg_in   = ry_ff[34];
            go_in    = 1'b1;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            if (div_res.done) begin
               if (corner_ff == 3'd7) begin
                  state_in = ST_FACE;
               end else begin
                  corner_in = corner_ff + 3'd1;
                  state_in  = ST_ROT;
               end
            end
         end
         ST_FACE: begin
            corner_in = '0;
            state_in  = ST_SORT;
         end
         ST_SORT: begin
            if (corner_ff == 3'd5) begin
               vert_in  = '0;
               state_in = ST_EMITV;
            end else begin
               corner_in = corner_ff + 3'd1;
            end
         end
         ST_EMITV: begin
            rsp_valid_in      = 1'b1;
            rsp_in.item_kind  = item_vertex;
            rsp_in.screen_x   = px_ff[vtx];
            rsp_in.screen_y   = py_ff[vtx];
            rsp_in.red        = SHADE_LUT[vert_ff][0];
            rsp_in.green      = SHADE_LUT[vert_ff][1];
            rsp_in.blue       = SHADE_LUT[vert_ff][2];
            if (vert_ff == 5'd23) begin
               slot_in  = '0;
               tri_in   = '0;
               state_in = ST_EMITI;
            end else begin
               vert_in = vert_ff + 5'd1;
            end
         end
         ST_EMITI: begin
            rsp_valid_in        = 1'b1;
            rsp_in.item_kind    = item_index;
            rsp_in.vertex_index = {order_ff[slot_ff], 2'b00} + 5'(TRI_PATTERN[tri_ff]);
            rsp_in.last         = (slot_ff == 3'd5) && (tri_ff == 3'd5);
            if (tri_ff == 3'd5) begin
               tri_in  = '0;
               slot_in = slot_ff + 3'd1;
               if (slot_ff == 3'd5) begin
                  state_in = ST_IDLE;
               end
            end else begin
               tri_in = tri_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      vert_ff   <= vert_in;
      slot_ff   <= slot_in;
      tri_ff    <= tri_in;
      ang_ff    <= ang_in;
      rx_ff     <= rx_in;
      rz_ff     <= rz_in;
      ry_ff     <= ry_in;
      cam_ff    <= cam_in;
      dv_ff     <= dv_in;
      den_ff    <= den_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
   end

   // store per-corner depth and projections, face sums and sorted order
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         depth_ff[corner_ff] <= cam_in;
      end
      if ((state_ff == ST_DIVX) && div_res.done) begin
         px_ff[corner_ff] <= div_res.quot;
      end
      if ((state_ff == ST_DIVY) && div_res.done) begin
         py_ff[corner_ff] <= div_res.quot;
      end
      if (state_ff == ST_FACE) begin
         for (int f = 0; f < 6; f++) begin
            fd_ff[f] <= {{2{depth_ff[FACE_RING[f][0]][37]}}, depth_ff[FACE_RING[f][0]]}
                      + {{2{depth_ff[FACE_RING[f][1]][37]}}, depth_ff[FACE_RING[f][1]]}
                      + {{2{depth_ff[FACE_RING[f][2]][37]}}, depth_ff[FACE_RING[f][2]]}
                      + {{2{depth_ff[FACE_RING[f][3]][37]}}, depth_ff[FACE_RING[f][3]]};
         end
      end
      if (state_ff == ST_SORT) begin
         order_ff[rank] <= corner_ff;
      end
   end

   crpds_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (go_ff),
      .mag    (mag_ff),
      .neg    (neg_ff),
      .den    (den_ff),
      .result (div_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/cube_rotate_project_depth_sort.sv -----
// Channel   Ports                        Handshake
// request   start, busy, req_data        taken when start && !busy
// result    rsp_valid, rsp_data          one cycle per result, no back-pressure
//
// Each request yields 60 results: 24 vertices, then 36 triangle indices.
// The engine pops a request, then per corner runs ST_ROT, ST_MUL, ST_NUMX, a division,
// ST_NUMY and a second division, then sums and sorts the faces and emits the results.
// Requests queue in front of the engine, so busy rises only when the queue is full.
// Synchronous active-high reset empties the queue and idles the engine.
// The results of one request leave in consecutive cycles; the receiver cannot stall them.
module cube_rotate_project_depth_sort #(
   parameter int QUEUE_DEPTH = crpds_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  crpds_pkg::req_type  req_data,
   output logic                rsp_valid,
   output crpds_pkg::rsp_type  rsp_data
);
   import crpds_pkg::*;

   queue_head_type head;
   logic           pop;

   crpds_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .pop      (pop),
      .busy     (busy),
      .head     (head)
   );

   crpds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // busy rises only after a request was taken
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // engine returns to idle after the last result
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result right after last");

   // index results run back to back until last
   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_kind && !rsp_data.last |=> rsp_valid)
      else $error("gap in index results");

   // vertices never carry last
   a_vertex_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.item_kind |-> !rsp_data.last)
      else $error("last on a vertex");

endmodule
